FILE: rtl/apc_pkg.sv
// Shared types and constants for the amicable pair check block.
package apc_pkg;

  // Extra bits above the value width that hold any proper divisor sum.
  localparam int unsigned SumGuardBits = 3;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LAUNCH = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } apc_state_e;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: rtl/apc_div.sv
// Shared restoring divider: one quotient bit per cycle.
module apc_div #(
  parameter int unsigned VALUE_BITS = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [VALUE_BITS-1:0]   dividend_i,
  input  logic [VALUE_BITS-1:0]   divisor_i,
  output apc_pkg::div_status_t    status_o,
  output logic [VALUE_BITS-1:0]   quot_o,
  output logic [VALUE_BITS-1:0]   rem_o
);

  localparam int unsigned CountBits = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [VALUE_BITS-1:0] div_q, div_d;
  logic [CountBits-1:0]  cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   divisor_ext;
  logic [VALUE_BITS:0]   diff;
  logic                  fits;

  assign shifted     = {rem_q, quo_q[VALUE_BITS-1]};
  assign divisor_ext = {1'b0, div_q};
  assign fits        = (shifted >= divisor_ext);
  assign diff        = shifted - divisor_ext;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = CountBits'(VALUE_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CountBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quo_q;
  assign rem_o         = rem_q;

endmodule

FILE: rtl/amicable_pair_check_unit.sv
// Top level: amicable pair test sequencer around a shared divider.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, first_value_i,    | input
//          | second_value_i                            |
//  out     | out_valid_o, out_ready_i, is_pair_o       | output
//
// Each number n is tested against candidates d = 1, 2, ... until n / d < d;
// every candidate costs one launch and one full run of the serial divider.
// Reset clears the sequencer and output valid; no clearing pass is needed.
// A held result in the output register stalls only the final step of the next pair.
module amicable_pair_check_unit #(
  parameter int unsigned VALUE_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] first_value_i,
  input  logic [VALUE_BITS-1:0] second_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_pair_o
);

  localparam int unsigned SumBits = VALUE_BITS + apc_pkg::SumGuardBits;

  apc_pkg::apc_state_e   state_q, state_d;
  logic                  phase_q, phase_d;
  logic                  out_valid_q, out_valid_d;
  logic                  is_pair_q, is_pair_d;
  logic [VALUE_BITS-1:0] a_q, a_d;
  logic [VALUE_BITS-1:0] b_q, b_d;
  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [VALUE_BITS-1:0] d_q, d_d;
  logic [SumBits-1:0]    sum_q, sum_d;
  logic [SumBits-1:0]    sum_a_q, sum_a_d;

  logic                  in_xfer;
  logic                  div_start;
  apc_pkg::div_status_t  div_status;
  logic [VALUE_BITS-1:0] quot;
  logic [VALUE_BITS-1:0] rem;
  logic [SumBits-1:0]    add_lo;
  logic [SumBits-1:0]    add_hi;
  logic [SumBits-1:0]    sum_next;

  apc_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .status_o  (div_status),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  assign in_ready_o = (state_q == apc_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign div_start  = (state_q == apc_pkg::S_LAUNCH);

  // Divisor d and its cofactor, each counted once and only when below n.
  assign add_lo   = (d_q < n_q) ? SumBits'(d_q) : '0;
  assign add_hi   = ((quot != d_q) && (quot < n_q)) ? SumBits'(quot) : '0;
  assign sum_next = sum_q + add_lo + add_hi;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    is_pair_d   = is_pair_q;
    a_d         = a_q;
    b_d         = b_q;
    n_d         = n_q;
    d_d         = d_q;
    sum_d       = sum_q;
    sum_a_d     = sum_a_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      apc_pkg::S_IDLE: begin
        if (in_xfer) begin
          a_d     = first_value_i;
          b_d     = second_value_i;
          n_d     = first_value_i;
          d_d     = VALUE_BITS'(1);
          sum_d   = '0;
          phase_d = 1'b0;
          state_d = apc_pkg::S_LAUNCH;
        end
      end
      apc_pkg::S_LAUNCH: begin
        state_d = apc_pkg::S_WAIT;
      end
      apc_pkg::S_WAIT: begin
        if (div_status.done) begin
          if (quot < d_q) begin
            // All candidates up to sqrt(n) tried.
            if (!phase_q) begin
              sum_a_d = sum_q;
              n_d     = b_q;
              d_d     = VALUE_BITS'(1);
              sum_d   = '0;
              phase_d = 1'b1;
              state_d = apc_pkg::S_LAUNCH;
            end else begin
              state_d = apc_pkg::S_FINISH;
            end
          end else begin
            if (rem == '0) begin
              sum_d = sum_next;
            end
            d_d     = d_q + 1'b1;
            state_d = apc_pkg::S_LAUNCH;
          end
        end
      end
      apc_pkg::S_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          is_pair_d   = (sum_a_q == SumBits'(b_q)) && (sum_q == SumBits'(a_q));
          out_valid_d = 1'b1;
          state_d     = apc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = apc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apc_pkg::S_IDLE;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_pair_q <= is_pair_d;
    a_q       <= a_d;
    b_q       <= b_d;
    n_q       <= n_d;
    d_q       <= d_d;
    sum_q     <= sum_d;
    sum_a_q   <= sum_a_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_pair_o   = is_pair_q;

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_status.busy)
    else $error("divider started while busy");

  a_candidate_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == apc_pkg::S_WAIT) |-> (d_q != '0))
    else $error("zero trial divisor");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == apc_pkg::S_FINISH))
    else $error("result raised outside finish step");

  a_transfer_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (!phase_q && (sum_q == '0) && (d_q == VALUE_BITS'(1))))
    else $error("new pair did not start from a clean sum");

endmodule
